FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FPO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpo check failed");

// Next-cycle implication.
`define FPO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpo check failed");

`endif

FILE: rtl/fpo_pkg.sv
package fpo_pkg;

  // Command codes of the input channel.
  localparam logic [1:0] CMD_VALID   = 2'd0;
  localparam logic [1:0] CMD_STRATUM = 2'd1;
  localparam logic [1:0] CMD_POINT   = 2'd2;
  localparam logic [1:0] CMD_RUN     = 2'd3;

  // Register indexes, byte address is 4 * index.
  localparam logic [1:0] REG_ROWS   = 2'd0;
  localparam logic [1:0] REG_COLS   = 2'd1;
  localparam logic [1:0] REG_POINTS = 2'd2;
  localparam logic [1:0] REG_PASSES = 2'd3;

  localparam int ROWS_W   = 13;
  localparam int COLS_W   = 13;
  localparam int PCOUNT_W = 7;
  localparam int PASS_W   = 4;

  localparam logic [ROWS_W-1:0]   ROWS_RST   = 13'd64;
  localparam logic [COLS_W-1:0]   COLS_RST   = 13'd64;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 7'd64;
  localparam logic [PASS_W-1:0]   PASS_RST   = 4'd5;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_CELL = 1'b1;

endpackage

FILE: rtl/farthest_point_optimizer_unit.sv
// Farthest-point optimiser for sample points on a toroidal grid (column-major cells).
// Input channel (in_valid/in_stall, fields cmd, cell_req, label): load commands append a
//   valid cell, set a cell's stratum label or append an initial point; each load
//   transaction is taken without a stall and returns nothing. A run transaction starts the
//   optimisation; in_stall stays high until every result of the run has been handed to
//   the output register.
// Output channel (out_valid/out_stall, fields slot, point_cell, stratum, status, last):
//   one transaction per point, slots in order, last set on the final one. A single output
//   register parts the channel from the core; while out_stall is high the result holds
//   and the sequencer waits in its emit step.
// A run with n points, V valid cells and P passes first splits each point cell into row
//   and column, then relocates every point once per pass against the V valid cells,
//   then reports the n points. The shared restoring divider (one quotient bit a cycle)
//   splits every cell into row and column; the five-step distance loop uses the single multiplier.
// Reset (rst, synchronous) returns the registers to their defaults and empties both
//   lists; the tables need no clearing pass. Configuration writes belong to idle time.
module farthest_point_optimizer_unit #(
  parameter int GRID_CELLS   = 4096,
  parameter int MAX_POINTS   = 64,
  parameter int STRATUM_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [$clog2(GRID_CELLS)-1:0]       cell_req,
  input  logic [STRATUM_BITS-1:0]             label,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(MAX_POINTS)-1:0]       slot,
  output logic [$clog2(GRID_CELLS)-1:0]       point_cell,
  output logic [STRATUM_BITS-1:0]             stratum,
  output logic                                status,
  output logic                                last
);
  import fpo_pkg::*;

  `include "assert_macros.svh"

  localparam int CELL_W = $clog2(GRID_CELLS);
  localparam int VFW    = $clog2(GRID_CELLS + 1);     // valid list fill / index
  localparam int NW     = $clog2(MAX_POINTS + 1);     // point count
  localparam int SW     = $clog2(MAX_POINTS);         // point index
  localparam int DW     = (CELL_W + 2 > 14) ? CELL_W + 2 : 14;
  localparam int PRW    = 2 * CELL_W;
  localparam int DIST_W = 2 * CELL_W + 1;
  localparam int CNT_W  = (CELL_W > 1) ? $clog2(CELL_W) : 1;
  localparam int PE_W   = 3 * CELL_W;                 // {cell, row, col}

  typedef enum logic [4:0] {
    S_IDLE, S_PREP_RD, S_PREP_LD, S_PREP_DIV, S_PREP_WR,
    S_PT_START, S_CAND_RD, S_CAND_LD, S_CAND_DIV,
    S_IN_RD, S_IN_A, S_IN_B, S_IN_C, S_IN_D, S_CAND_EVAL, S_PT_END,
    S_OUT_RD, S_OUT_SA, S_OUT_SW, S_OUT_EMIT
  } state_t;

  state_t                state;
  logic [ROWS_W-1:0]     grid_rows;
  logic [COLS_W-1:0]     grid_cols;
  logic [PCOUNT_W-1:0]   point_count;
  logic [PASS_W-1:0]     pass_count;
  logic [VFW-1:0]        valid_fill;
  logic [NW-1:0]         point_fill;
  logic [NW-1:0]         n, j, i;
  logic [VFW-1:0]        k;
  logic [PASS_W-1:0]     pass;
  logic [MAX_POINTS-1:0] failed;
  logic [CELL_W-1:0]     dq, drem;         // divider: quotient (column), remainder (row)
  logic [CNT_W-1:0]      dcnt;
  logic [CELL_W-1:0]     cand;
  logic [CELL_W-1:0]     best_cell, best_row, best_col;
  logic [DIST_W-1:0]     best_dist, nearest;
  logic                  best_none, occ;
  logic [CELL_W-1:0]     dr_q, dc_q;
  logic                  same_q, skip_q;
  logic [PRW-1:0]        prod, acc;
  logic [CELL_W-1:0]     sa;

  // memories
  logic [CELL_W-1:0]       vmem [GRID_CELLS];
  logic [STRATUM_BITS-1:0] smem [GRID_CELLS];
  logic [PE_W-1:0]         pmem [MAX_POINTS];
  logic [CELL_W-1:0]       vrd;
  logic [STRATUM_BITS-1:0] srd;
  logic [PE_W-1:0]         prd;

  function automatic logic [CELL_W-1:0] axis_delta(input logic [CELL_W-1:0] a,
                                                   input logic [CELL_W-1:0] b,
                                                   input logic [12:0] size);
    logic [CELL_W-1:0] d;
    logic [DW-1:0]     dx, sz;
    d  = (a > b) ? a - b : b - a;
    dx = DW'(d);
    sz = DW'(size);
    if ((dx << 1) > sz && dx <= sz) d = CELL_W'(sz - dx);
    return d;
  endfunction

  // --- combinational helpers ---
  logic              cfg_wr, in_acc;
  logic              emit_go;
  logic [ROWS_W-1:0] rdiv;
  logic [DW-1:0]     trial;
  logic              trial_ge;
  logic [CELL_W-1:0] mop;
  logic [PRW-1:0]    mprod;
  logic [DIST_W-1:0] dsum;
  logic [NW-1:0]     n_calc;
  logic              cell_ok;
  logic              pwe;
  logic [SW-1:0]     pwa, pra;
  logic [PE_W-1:0]   pwd;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // output register free this cycle while the sequencer sits in its emit step
  assign emit_go  = (state == S_OUT_EMIT) && (!out_valid || !out_stall);

  assign rdiv     = (grid_rows == '0) ? ROWS_W'(1) : grid_rows;
  assign trial    = DW'({drem, dq[CELL_W-1]});
  assign trial_ge = trial >= DW'(rdiv);

  assign mop   = (state == S_IN_B) ? dr_q : dc_q;
  assign mprod = PRW'(mop) * PRW'(mop);
  assign dsum  = DIST_W'(acc) + DIST_W'(prod);

  assign n_calc  = (point_count < PCOUNT_W'(point_fill)) ? NW'(point_count) : point_fill;
  assign cell_ok = (CELL_W + 1)'(cell_req) < (CELL_W + 1)'(GRID_CELLS);
  assign pra     = (state == S_IN_RD) ? i[SW-1:0] : j[SW-1:0];

  always_comb begin
    pwe = 1'b0;
    pwa = j[SW-1:0];
    pwd = {best_cell, best_row, best_col};
    case (state)
      S_IDLE: begin
        pwe = in_acc && cmd == CMD_POINT && cell_ok && point_fill < NW'(MAX_POINTS);
        pwa = point_fill[SW-1:0];
        pwd = {cell_req, {(2 * CELL_W){1'b0}}};
      end
      S_PREP_WR: begin
        pwe = 1'b1;
        pwd = {cand, drem, dq};
      end
      S_PT_END: pwe = !best_none;
      default: pwe = 1'b0;
    endcase
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:   prdata = 32'(grid_rows);
      REG_COLS:   prdata = 32'(grid_cols);
      REG_POINTS: prdata = 32'(point_count);
      REG_PASSES: prdata = 32'(pass_count);
      default:    prdata = '0;
    endcase
  end

  // --- memories ---
  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_VALID && cell_ok && valid_fill < VFW'(GRID_CELLS))
      vmem[valid_fill[CELL_W-1:0]] <= cell_req;
    if (in_acc && cmd == CMD_STRATUM && cell_ok)
      smem[cell_req] <= label;
    if (pwe)
      pmem[pwa] <= pwd;
    vrd <= vmem[k[CELL_W-1:0]];
    srd <= smem[sa];
    prd <= pmem[pra];
  end

  // --- sequencer ---
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      grid_rows   <= ROWS_RST;
      grid_cols   <= COLS_RST;
      point_count <= PCOUNT_RST;
      pass_count  <= PASS_RST;
      valid_fill  <= '0;
      point_fill  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ROWS:   grid_rows   <= pwdata[ROWS_W-1:0];
          REG_COLS:   grid_cols   <= pwdata[COLS_W-1:0];
          REG_POINTS: point_count <= pwdata[PCOUNT_W-1:0];
          REG_PASSES: pass_count  <= pwdata[PASS_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && !emit_go) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cmd == CMD_RUN) begin
              if (n_calc != '0) begin
                n      <= n_calc;
                j      <= '0;
                pass   <= '0;
                failed <= '0;
                state  <= S_PREP_RD;
              end
            end else if (cell_ok) begin
              if (cmd == CMD_VALID && valid_fill < VFW'(GRID_CELLS))
                valid_fill <= valid_fill + 1'b1;
              if (cmd == CMD_POINT && point_fill < NW'(MAX_POINTS))
                point_fill <= point_fill + 1'b1;
            end
          end
        end
        // split each point cell into row and column for this run
        S_PREP_RD: state <= S_PREP_LD;
        S_PREP_LD: begin
          cand  <= prd[PE_W-1 -: CELL_W];
          dq    <= prd[PE_W-1 -: CELL_W];
          drem  <= '0;
          dcnt  <= '0;
          state <= S_PREP_DIV;
        end
        S_PREP_DIV: begin
          drem <= trial_ge ? CELL_W'(trial - DW'(rdiv)) : CELL_W'(trial);
          dq   <= {dq[CELL_W-2:0], trial_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == CNT_W'(CELL_W - 1)) state <= S_PREP_WR;
        end
        S_PREP_WR: begin
          if (j + 1'b1 == n) begin
            j     <= '0;
            state <= (pass_count == '0) ? S_OUT_RD : S_PT_START;
          end else begin
            j     <= j + 1'b1;
            state <= S_PREP_RD;
          end
        end
        // relocate point j
        S_PT_START: begin
          best_none <= 1'b1;
          best_dist <= '0;
          k         <= '0;
          state     <= (valid_fill == '0) ? S_PT_END : S_CAND_RD;
        end
        S_CAND_RD: state <= S_CAND_LD;
        S_CAND_LD: begin
          cand  <= vrd;
          dq    <= vrd;
          drem  <= '0;
          dcnt  <= '0;
          state <= S_CAND_DIV;
        end
        S_CAND_DIV: begin
          drem <= trial_ge ? CELL_W'(trial - DW'(rdiv)) : CELL_W'(trial);
          dq   <= {dq[CELL_W-2:0], trial_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == CNT_W'(CELL_W - 1)) begin
            i       <= '0;
            nearest <= '1;
            occ     <= 1'b0;
            state   <= S_IN_RD;
          end
        end
        // nearest other point to the candidate; also spots an occupied candidate
        S_IN_RD: state <= S_IN_A;
        S_IN_A: begin
          skip_q <= (i == j);
          same_q <= (prd[PE_W-1 -: CELL_W] == cand);
          dr_q   <= axis_delta(prd[2*CELL_W-1 -: CELL_W], drem, rdiv);
          dc_q   <= axis_delta(prd[CELL_W-1:0], dq, grid_cols);
          state  <= S_IN_B;
        end
        S_IN_B: begin
          prod  <= mprod;
          state <= S_IN_C;
        end
        S_IN_C: begin
          acc   <= prod;
          prod  <= mprod;
          state <= S_IN_D;
        end
        S_IN_D: begin
          if (!skip_q) begin
            if (dsum < nearest) nearest <= dsum;
            if (same_q) occ <= 1'b1;
          end
          i     <= i + 1'b1;
          state <= (i + 1'b1 == n) ? S_CAND_EVAL : S_IN_RD;
        end
        S_CAND_EVAL: begin
          // strict compare keeps the earliest candidate on a tie
          if (!occ && (best_none || nearest > best_dist)) begin
            best_none <= 1'b0;
            best_dist <= nearest;
            best_cell <= cand;
            best_row  <= drem;
            best_col  <= dq;
          end
          k     <= k + 1'b1;
          state <= (k + 1'b1 == valid_fill) ? S_PT_END : S_CAND_RD;
        end
        S_PT_END: begin
          if (best_none) failed[j[SW-1:0]] <= 1'b1;
          if (j + 1'b1 == n) begin
            j <= '0;
            if (pass + 1'b1 == pass_count) begin
              state <= S_OUT_RD;
            end else begin
              pass  <= pass + 1'b1;
              state <= S_PT_START;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_PT_START;
          end
        end
        // report one transaction per point
        S_OUT_RD: state <= S_OUT_SA;
        S_OUT_SA: begin
          sa    <= prd[PE_W-1 -: CELL_W];
          state <= S_OUT_SW;
        end
        S_OUT_SW: state <= S_OUT_EMIT;
        S_OUT_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            slot       <= j[SW-1:0];
            point_cell <= sa;
            stratum    <= srd;
            status     <= failed[j[SW-1:0]] ? STATUS_NO_CELL : STATUS_OK;
            last       <= (j + 1'b1 == n);
            if (j + 1'b1 == n) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --- checks ---
  `FPO_ASSERT_IMP(a_result_from_emit, $rose(out_valid), $past(state) == S_OUT_EMIT)
  `FPO_ASSERT_IMP(a_inner_loop_done, state == S_CAND_EVAL, i == n)
  `FPO_ASSERT_IMP(a_point_in_range, state == S_PT_START, j < n)
  `FPO_ASSERT_NXT(a_last_ends_run, emit_go && j + 1'b1 == n, state == S_IDLE && last)

endmodule

FILE: test/farthest_point_optimizer_unit_test.sv
module farthest_point_optimizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpo_pkg::*;

  localparam int GRID     = 4096;
  localparam int MAXP     = 64;
  localparam int IDLE_MAX = 1000000;
  localparam int N_ITEMS  = 320;
  localparam int V_CAP    = 40;      // keeps the valid list short, runs stay quick
  localparam int P_CAP    = 12;      // likewise for the point list
  localparam logic [24:0] NO_NEAR = 25'h1FFFFFF;

  // one reported point
  typedef struct {
    logic [5:0]  slot;
    logic [11:0] pcell;
    logic [7:0]  strat;
    logic        status;
    logic        last;
  } placement_t;

  // directed row: either a register write or an input transaction
  typedef struct {
    logic        is_reg;
    logic [1:0]  code;      // register index or command
    logic [12:0] value;     // register value or cell
    logic [7:0]  lab;
    logic        typed;     // expected single placement given below
    logic [11:0] e_cell;
    logic [7:0]  e_strat;
    logic        e_status;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = CMD_VALID;
  logic [11:0] cell_req = '0;
  logic [7:0]  label = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  slot;
  logic [11:0] point_cell;
  logic [7:0]  stratum;
  logic        status;
  logic        last;

  farthest_point_optimizer_unit u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .cmd, .cell_req, .label,
    .out_valid, .out_stall, .slot, .point_cell, .stratum, .status, .last
  );

  always #4 clk = ~clk;

  // shadow of the block: registers, lists, labels
  logic [12:0] sh_rows, sh_cols;
  logic [6:0]  sh_pcount;
  logic [3:0]  sh_passes;
  logic [11:0] cell_list [GRID];
  int unsigned cell_fill;
  logic [7:0]  label_of [GRID];
  logic [11:0] pts [MAXP];
  int unsigned pt_fill;
  int unsigned occ [GRID];

  placement_t placements_due [$];
  placement_t run_out [$];

  int  n_err = 0;
  int  n_items = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;      // no sender gaps while set
  bit  hold_req = 1'b0;  // receiver takes a long hold-off once

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned axis_gap(int unsigned a, int unsigned b,
                                           int unsigned size);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    // wrap only while the delta still fits the axis
    if (2 * d > size && d <= size) d = size - d;
    return d;
  endfunction

  function automatic int unsigned dist2(int unsigned c1, int unsigned c2);
    int unsigned r, dr, dc;
    r  = (sh_rows == 0) ? 1 : sh_rows;   // zero rows counts as one
    dr = axis_gap(c1 % r, c2 % r, r);
    dc = axis_gap(c1 / r, c2 / r, sh_cols);
    return dr * dr + dc * dc;
  endfunction

  function automatic int unsigned nearest_point(int unsigned c, int unsigned n,
                                                int unsigned skip);
    int unsigned best, d;
    best = NO_NEAR;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == skip) continue;
      d = dist2(pts[i], c);
      if (d < best) best = d;
    end
    return best;
  endfunction

  // whole run: relocation passes, then one placement per point
  function automatic void optimise_points();
    int unsigned n, cur, cand, d, bdist;
    int          bcell;
    bit          failed [MAXP];
    placement_t  pl;
    run_out.delete();
    n = sh_pcount;
    if (n > pt_fill) n = pt_fill;
    if (n > MAXP) n = MAXP;
    if (n == 0) return;
    for (int i = 0; i < GRID; i++) occ[i] = 0;
    for (int unsigned j = 0; j < n; j++) begin
      occ[pts[j]]++;
      failed[j] = 1'b0;
    end
    for (int unsigned p = 0; p < sh_passes; p++) begin
      for (int unsigned j = 0; j < n; j++) begin
        cur = pts[j];
        if (occ[cur] > 0) occ[cur]--;
        bcell = -1;
        bdist = 0;
        for (int unsigned k = 0; k < cell_fill; k++) begin
          cand = cell_list[k];
          if (occ[cand] != 0) continue;
          d = nearest_point(cand, n, j);
          if (bcell < 0 || d > bdist) begin
            bdist = d;
            bcell = cand;
          end
        end
        if (bcell < 0) begin
          failed[j] = 1'b1;   // nothing free: stays put
          occ[cur]++;
        end else begin
          occ[bcell]++;
          pts[j] = bcell[11:0];
        end
      end
    end
    for (int unsigned j = 0; j < n; j++) begin
      pl.slot   = j[5:0];
      pl.pcell  = pts[j];
      pl.strat  = label_of[pts[j]];
      pl.status = failed[j] ? STATUS_NO_CELL : STATUS_OK;
      pl.last   = (j + 1 == n);
      run_out.insert(run_out.size(), pl);
    end
  endfunction

  function automatic void apply_item(logic [1:0] c, logic [11:0] cl, logic [7:0] lb);
    run_out.delete();
    case (c)
      CMD_VALID: begin
        if (cell_fill < GRID) begin
          cell_list[cell_fill] = cl;
          cell_fill++;
        end
      end
      CMD_STRATUM: label_of[cl] = lb;
      CMD_POINT: begin
        if (pt_fill < MAXP) begin
          pts[pt_fill] = cl;
          pt_fill++;
        end
      end
      default: optimise_points();
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_item(input logic [1:0] c, input logic [11:0] cl,
                           input logic [7:0] lb, input row_t r);
    int gap;
    placement_t pl;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    cell_req <= cl;
    label    <= lb;
    do @(posedge clk); while (in_stall);
    apply_item(c, cl, lb);
    n_items++;
    if (r.typed) begin
      pl.slot = '0; pl.pcell = r.e_cell; pl.strat = r.e_strat;
      pl.status = r.e_status; pl.last = 1'b1;
      placements_due.insert(placements_due.size(), pl);
    end else begin
      foreach (run_out[i]) placements_due.insert(placements_due.size(), run_out[i]);
    end
  endtask

  // quiet the input and let everything drain before a register write
  task automatic drain_quiet();
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROWS:   sh_rows   = v[12:0];
      REG_COLS:   sh_cols   = v[12:0];
      REG_POINTS: sh_pcount = v[6:0];
      default:    sh_passes = v[3:0];
    endcase
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        // long hold-off: the output register fills and the input stalls
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      w = calm ? 0 : $urandom_range(0, 5);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    placement_t e;
    if (!rst && out_valid && !out_stall) begin
      if (placements_due.size() == 0) begin
        $error("unexpected result transaction, slot %0d", slot);
        n_err++;
      end else begin
        e = placements_due.pop_front();
        if (slot !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot); n_err++;
        end
        if (point_cell !== e.pcell) begin
          $error("point_cell: expected %0d, got %0d", e.pcell, point_cell); n_err++;
        end
        if (stratum !== e.strat) begin
          $error("stratum: expected %0d, got %0d", e.strat, stratum); n_err++;
        end
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status); n_err++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last); n_err++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("farthest_point_optimizer_unit_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic row_t item_row(logic [1:0] c, logic [12:0] v, logic [7:0] lb);
    row_t r;
    r = '{1'b0, c, v, lb, 1'b0, 12'd0, 8'd0, 1'b0};
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [12:0] v);
    row_t r;
    r = '{1'b1, idx, v, 8'd0, 1'b0, 12'd0, 8'd0, 1'b0};
    return r;
  endfunction

  function automatic row_t run_typed(logic [11:0] c, logic [7:0] s, logic st);
    row_t r;
    r = '{1'b0, CMD_RUN, 13'd0, 8'd0, 1'b1, c, s, st};
    return r;
  endfunction

  // one random point or valid cell append, always followed by its label
  task automatic add_cell(input logic [1:0] c, input bit from_list);
    logic [11:0] cl;
    row_t nr;
    nr = item_row(CMD_RUN, 13'd0, 8'd0);
    if (from_list && cell_fill > 0) cl = cell_list[$urandom_range(0, cell_fill - 1)];
    else cl = 12'($urandom_range(0, GRID - 1));
    send_item(c, cl, 8'($urandom_range(0, 255)), nr);
    send_item(CMD_STRATUM, cl, 8'($urandom_range(0, 255)), nr);
  endtask

  initial begin
    row_t dir_tab [$];
    row_t nr;
    int   seq, n_loads, pt_adds, pick;
    bit   big_pc;

    sh_rows = ROWS_RST; sh_cols = COLS_RST;
    sh_pcount = PCOUNT_RST; sh_passes = PASS_RST;
    cell_fill = 0; pt_fill = 0;
    for (int i = 0; i < GRID; i++) label_of[i] = '0;
    nr = item_row(CMD_RUN, 13'd0, 8'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    dir_tab = '{
      item_row(CMD_RUN, 13'd0, 8'd0),           // nothing loaded: no results
      item_row(CMD_VALID, 13'd0, 8'd0),
      item_row(CMD_STRATUM, 13'd0, 8'd0),
      item_row(CMD_VALID, 13'd4095, 8'd0),
      item_row(CMD_STRATUM, 13'd4095, 8'd255),
      item_row(CMD_POINT, 13'd0, 8'd0),
      run_typed(12'd0, 8'd0, STATUS_OK),         // lone point: first free cell
      reg_row(REG_PASSES, 13'd15),
      reg_row(REG_POINTS, 13'd1),
      item_row(CMD_POINT, 13'd4095, 8'd0),
      run_typed(12'd0, 8'd0, STATUS_OK),         // only the first point takes part
      reg_row(REG_POINTS, 13'd64),
      reg_row(REG_ROWS, 13'd0),                  // zero rows
      reg_row(REG_COLS, 13'd0),                  // columns never wrap
      item_row(CMD_POINT, 13'd100, 8'd0),
      item_row(CMD_STRATUM, 13'd100, 8'ha5),
      item_row(CMD_RUN, 13'd0, 8'd0),            // third point finds nothing free
      reg_row(REG_ROWS, 13'd4096),
      reg_row(REG_COLS, 13'd4096),
      reg_row(REG_PASSES, 13'd1),
      item_row(CMD_VALID, 13'd2049, 8'd0),
      item_row(CMD_STRATUM, 13'd2049, 8'h5a),
      item_row(CMD_RUN, 13'd0, 8'd0),
      reg_row(REG_PASSES, 13'd0),                // no passes: points unchanged
      item_row(CMD_RUN, 13'd0, 8'd0)
    };

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        drain_quiet();
        reg_write(dir_tab[i].code, {19'd0, dir_tab[i].value});
      end else begin
        send_item(dir_tab[i].code, dir_tab[i].value[11:0], dir_tab[i].lab, dir_tab[i]);
      end
    end
    drain_quiet();
    reg_write(REG_ROWS, 32'd8191);
    reg_write(REG_COLS, 32'd8191);
    reg_write(REG_POINTS, 32'd0);                // zero points: run gives nothing
    send_item(CMD_RUN, 12'd0, 8'd0, nr);

    // random sequences: register settings, loads, then a run
    seq = 0;
    while (n_items < N_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      big_pc = 1'b0;
      if (seq == 0 || $urandom_range(0, 2) == 0) begin
        drain_quiet();
        reg_write(REG_ROWS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(1, 64));
        reg_write(REG_COLS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                        : $urandom_range(1, 64));
        if (pt_fill <= 4 && $urandom_range(0, 2) == 0) begin
          big_pc = 1'b1;
          reg_write(REG_POINTS, $urandom_range(0, 1) ? 32'd64 : 32'd127);
        end else begin
          reg_write(REG_POINTS, $urandom_range(0, 8));
        end
        // many passes only with few points
        if (sh_pcount <= 2 && $urandom_range(0, 2) == 0) reg_write(REG_PASSES, 32'd15);
        else reg_write(REG_PASSES, $urandom_range(0, 4));
      end
      n_loads = $urandom_range(2, 8);
      pt_adds = 0;
      for (int k = 0; k < n_loads; k++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 3 && cell_fill < V_CAP) begin
          add_cell(CMD_VALID, 1'b0);
        end else if (pick <= 6 && pt_adds < 3 && pt_fill < P_CAP &&
                     !(big_pc && pt_fill >= 4)) begin
          add_cell(CMD_POINT, $urandom_range(0, 1));
          pt_adds++;
        end else begin
          send_item(CMD_STRATUM, 12'($urandom_range(0, GRID - 1)),
                    8'($urandom_range(0, 255)), nr);
        end
      end
      if (seq == 3) hold_req = 1'b1;
      send_item(CMD_RUN, 12'($urandom_range(0, GRID - 1)), 8'($urandom_range(0, 255)), nr);
      // the sender pauses now and then until every placement is in
      if ($urandom_range(0, 5) == 0) drain_quiet();
      seq++;
    end

    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_err == 0) $display("farthest_point_optimizer_unit_test: clean");
    else $display("farthest_point_optimizer_unit_test: errors");
    $finish;
  end

endmodule
